### rtl/rpvg_pkg.sv
package rpvg_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int CORDIC_STEPS = 16;
    localparam int COORD_BITS   = 16;

    // datapath widths
    localparam int XY_W    = 44;   // CORDIC x/y, holds dx * 2^24 times gain
    localparam int Z_W     = 34;   // CORDIC angle, 32-bit turns plus headroom
    localparam int STEP_W  = 5;    // CORDIC step index, up to 24 steps
    localparam int RAD_W   = 25;   // radius, 8 fraction bits
    localparam int SQ_IN_W = 50;   // sqrt radicand
    localparam int REM_W   = 28;   // sqrt partial remainder
    localparam int CNT_W   = 7;    // vertex count

    localparam logic signed [Z_W-1:0] TURN_HALF    = Z_W'(64'sd2147483648);
    localparam logic signed [Z_W-1:0] TURN_QUARTER = Z_W'(64'sd1073741824);
    localparam logic signed [XY_W-1:0] GAIN_Q30    = XY_W'(64'sd652032874);

    typedef struct packed {
        logic                   valid;
        logic                   vec;   // 1: vectoring, 0: rotation
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } cordic_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SQR, S_ITER, S_VEC, S_VWAIT, S_ROT, S_RWAIT, S_MUL, S_PLACE, S_OUT
    } state_t;

    // atan(2^-k) in 32-bit binary turns
    function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] k);
        logic [31:0] r;
        case (k)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2F9;
            5'd15:   r = 32'h0000517C;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A2F;
            5'd19:   r = 32'h00000517;
            5'd20:   r = 32'h0000028B;
            5'd21:   r = 32'h00000145;
            5'd22:   r = 32'h000000A2;
            5'd23:   r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

### rtl/rpvg_cordic_cell.sv
module rpvg_cordic_cell
    import rpvg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [STEP_W-1:0] step,
    input  cordic_t           d_in,
    output cordic_t           d_out
);

    cordic_t                d_reg;
    cordic_t                d_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;
    logic signed [Z_W-1:0]  at;
    logic                   pos;

    // one micro-rotation; direction from y when vectoring, from z when rotating
    always_comb
    begin
        xs  = d_in.x >>> step;
        ys  = d_in.y >>> step;
        at  = $signed({2'b00, cordic_atan(step)});
        pos = d_in.vec ? !d_in.y[XY_W-1] : !d_in.z[Z_W-1];
        d_next       = d_in;
        if (d_in.vec == pos)
        begin
            d_next.x = d_in.x + ys;
            d_next.y = d_in.y - xs;
            d_next.z = d_in.z + at;
        end
        else
        begin
            d_next.x = d_in.x - ys;
            d_next.y = d_in.y + xs;
            d_next.z = d_in.z - at;
        end
    end

    // stage register, valid and data move together
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_reg <= '0;
        end
        else
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

### rtl/rpvg_cordic_chain.sv
module rpvg_cordic_chain
    import rpvg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cordic_t d_in,
    output cordic_t d_out
);

    cordic_t link [CORDIC_STEPS+1];

    assign link[0] = d_in;

    // row of CORDIC cells, cell g does step g
    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cell
        rpvg_cordic_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (STEP_W'(g)),
            .d_in  (link[g]),
            .d_out (link[g+1])
        );
    end

    assign d_out = link[CORDIC_STEPS];

endmodule

### rtl/regular_polygon_vertex_gen.sv
// Regular polygon vertex generator.
// Input channel (in_valid/in_ready): center, a rim point and a vertex count.
// The radius is the distance to the rim point and the start angle its
// direction; the count is clamped to 3..64.
// Output channel (out_valid/out_ready): one transaction per vertex, in index
// order, with last set on the final one.
// Only one polygon is in work at a time; in_ready is high only while idle.
// Work runs in order: a squaring, 25 sqrt steps run alongside the
// angle-step division, a pass through the CORDIC row for atan2, then per
// vertex: its sin/cos passes the 16-cell CORDIC row once, then a
// multiply, a place stage and the output state.
// When the receiver stalls the vertex stays in the output register and the
// block waits; nothing is dropped. Reset returns the block to idle.
module regular_polygon_vertex_gen
    import rpvg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] center_x,
    input  logic signed [15:0] center_y,
    input  logic signed [15:0] rim_x,
    input  logic signed [15:0] rim_y,
    input  logic [6:0]         vertex_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] vertex_x,
    output logic signed [15:0] vertex_y,
    output logic [5:0]         vertex_index,
    output logic               last
);

    localparam logic signed [XY_W-1:0] LIM_HI = XY_W'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic signed [XY_W-1:0] LIM_LO = -LIM_HI - 1;
    localparam logic signed [XY_W-1:0] TRUNC_ADJ = XY_W'(64'sd8388607);

    state_t                  state_reg, state_next;
    logic signed [15:0]      cx_reg, cy_reg;
    logic signed [16:0]      dx_reg, dy_reg;
    logic [CNT_W-1:0]        n_reg;
    logic [SQ_IN_W-1:0]      v_reg, v_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [RAD_W-1:0]        root_reg, root_next;
    logic [7:0]              drem_reg, drem_next;
    logic [16:0]             q_reg, q_next;
    logic [4:0]              cnt_reg, cnt_next;
    logic                    zero_reg;
    logic [15:0]             start_reg, start_next;
    logic [15:0]             accq_reg, accq_next;
    logic [CNT_W-1:0]        accr_reg, accr_next;
    logic [5:0]              idx_reg, idx_next;
    logic                    neg_reg, neg_next;
    logic signed [16:0]      cos_reg, cos_next, sin_reg, sin_next;
    logic signed [XY_W-1:0]  px_reg, py_reg;
    logic signed [15:0]      vx_reg, vy_reg;
    logic                    is_last;

    cordic_t                 ch_in, ch_out;

    logic signed [33:0]      sq_sum;
    logic [REM_W-1:0]        rem_sh, trial;
    logic [7:0]              drem_sh;
    logic [7:0]              accr_sum;
    logic [15:0]             angle;
    logic signed [Z_W-1:0]   zr;
    logic [31:0]             zround;
    logic [CNT_W-1:0]        n_clamp;

    // rounds a Q2.30 value to Q1.15 and clamps to +-1.0
    function automatic logic signed [16:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + XY_W'(64'sd16384)) >>> 15;
        if (r > XY_W'(64'sd32768))
            r = XY_W'(64'sd32768);
        if (r < -XY_W'(64'sd32768))
            r = -XY_W'(64'sd32768);
        return r[16:0];
    endfunction

    // center plus radius*trig, truncated toward zero, saturated
    function automatic logic signed [15:0] place(input logic signed [15:0] c,
                                                 input logic signed [XY_W-1:0] p);
        logic signed [XY_W-1:0]       s;
        logic signed [XY_W-1:0]       v;
        logic signed [COORD_BITS-1:0] sat;
        s = $signed({{(XY_W-39){c[15]}}, c, 23'b0}) + p;
        if (s < 0)
            s = s + TRUNC_ADJ;
        v = s >>> 23;
        if (v > LIM_HI)
            v = LIM_HI;
        if (v < LIM_LO)
            v = LIM_LO;
        sat = v[COORD_BITS-1:0];
        return 16'(sat);
    endfunction

    assign is_last  = ({1'b0, idx_reg} == n_reg - CNT_W'(1));
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign vertex_x = vx_reg;
    assign vertex_y = vy_reg;
    assign vertex_index = idx_reg;
    assign last = is_last;

    // count clamp
    always_comb
    begin
        if (vertex_count < CNT_W'(3))
            n_clamp = CNT_W'(3);
        else if (vertex_count > CNT_W'(MAX_VERTICES))
            n_clamp = CNT_W'(MAX_VERTICES);
        else
            n_clamp = vertex_count;
    end

    rpvg_cordic_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .d_in  (ch_in),
        .d_out (ch_out)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        drem_next  = drem_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        accq_next  = accq_reg;
        accr_next  = accr_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        ch_in      = '0;

        sq_sum   = dx_reg * dx_reg + dy_reg * dy_reg;
        rem_sh   = {rem_reg[REM_W-3:0], v_reg[SQ_IN_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        drem_sh  = {drem_reg[6:0], (cnt_reg == 5'd0)};
        accr_sum = {1'b0, accr_reg} + {1'b0, drem_reg[CNT_W-1:0]};
        angle    = start_reg + accq_reg;
        zr       = $signed({{(Z_W-32){angle[15]}}, angle, 16'b0});
        zround   = ch_out.z[31:0] + 32'h8000;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SQR;
            end
            S_SQR:
            begin
                v_next     = {sq_sum[33:0], 16'b0};
                rem_next   = '0;
                root_next  = '0;
                drem_next  = '0;
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_ITER;
            end
            S_ITER:
            begin
                // one sqrt digit per cycle; division runs in the first 17 steps
                v_next = v_reg << 2;
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[RAD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[RAD_W-2:0], 1'b0};
                end
                if (cnt_reg < 5'd17)
                begin
                    if (drem_sh >= {1'b0, n_reg})
                    begin
                        drem_next = drem_sh - {1'b0, n_reg};
                        q_next    = {q_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        drem_next = drem_sh;
                        q_next    = {q_reg[15:0], 1'b0};
                    end
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(RAD_W - 1))
                    state_next = S_VEC;
            end
            S_VEC:
            begin
                ch_in.valid = 1'b1;
                ch_in.vec   = 1'b1;
                ch_in.x     = $signed({{(XY_W-41){dx_reg[16]}}, dx_reg, 24'b0});
                ch_in.y     = $signed({{(XY_W-41){dy_reg[16]}}, dy_reg, 24'b0});
                ch_in.z     = '0;
                if (dx_reg < 0)
                begin
                    ch_in.x = -ch_in.x;
                    ch_in.y = -ch_in.y;
                    ch_in.z = TURN_HALF;
                end
                state_next = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (ch_out.valid)
                begin
                    start_next = zero_reg ? 16'h0 : zround[31:16];
                    accq_next  = '0;
                    accr_next  = '0;
                    idx_next   = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT:
            begin
                ch_in.valid = 1'b1;
                ch_in.vec   = 1'b0;
                ch_in.x     = GAIN_Q30;
                ch_in.y     = '0;
                ch_in.z     = zr;
                neg_next    = 1'b0;
                if (zr > TURN_QUARTER)
                begin
                    ch_in.z  = zr - TURN_HALF;
                    neg_next = 1'b1;
                end
                else if (zr < -TURN_QUARTER)
                begin
                    ch_in.z  = zr + TURN_HALF;
                    neg_next = 1'b1;
                end
                // next angle offset: floor(i * 65536 / n) by quotient and remainder
                if (accr_sum >= {1'b0, n_reg})
                begin
                    accr_next = CNT_W'(accr_sum - {1'b0, n_reg});
                    accq_next = accq_reg + q_reg[15:0] + 16'd1;
                end
                else
                begin
                    accr_next = accr_sum[CNT_W-1:0];
                    accq_next = accq_reg + q_reg[15:0];
                end
                state_next = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (ch_out.valid)
                begin
                    cos_next   = to_q15(neg_reg ? -ch_out.x : ch_out.x);
                    sin_next   = to_q15(neg_reg ? -ch_out.y : ch_out.y);
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (is_last)
                        state_next = S_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 6'd1;
                        state_next = S_ROT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cx_reg   <= center_x;
            cy_reg   <= center_y;
            dx_reg   <= 17'(rim_x) - 17'(center_x);
            dy_reg   <= 17'(rim_y) - 17'(center_y);
            n_reg    <= n_clamp;
            zero_reg <= (rim_x == center_x) && (rim_y == center_y);
        end
        v_reg     <= v_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        drem_reg  <= drem_next;
        q_reg     <= q_next;
        cnt_reg   <= cnt_next;
        start_reg <= start_next;
        accq_reg  <= accq_next;
        accr_reg  <= accr_next;
        idx_reg   <= idx_next;
        neg_reg   <= neg_next;
        cos_reg   <= cos_next;
        sin_reg   <= sin_next;
        if (state_reg == S_MUL)
        begin
            px_reg <= XY_W'($signed({1'b0, root_reg}) * cos_reg);
            py_reg <= XY_W'($signed({1'b0, root_reg}) * sin_reg);
        end
        if (state_reg == S_PLACE)
        begin
            vx_reg <= place(cx_reg, px_reg);
            vy_reg <= place(cy_reg, py_reg);
        end
    end

    // checks
    a_chain_out_expected: assert property (@(posedge clk) disable iff (!rst_n)
        ch_out.valid |-> (state_reg == S_VWAIT || state_reg == S_RWAIT))
        else $error("CORDIC result arrived outside a wait state");

    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROT) |-> (accr_reg < n_reg))
        else $error("angle step remainder not below vertex count");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_SQR))
        else $error("accepted transaction did not start work");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not idle after final vertex");

endmodule
